### rtl/core/dept_pkg.sv
// Shared types and constants of the dual encoder period tachometer.
package dept_pkg;

   localparam int TS_W       = 32;  // timestamp field width
   localparam int PPR_W      = 16;  // pulses per revolution register width
   localparam int TICK_W     = 27;  // tick rate register width
   localparam int TIMEOUT_W  = 32;  // stall timeout register width
   localparam int RPM_W      = 41;  // speed field width
   localparam int TICKX60_W  = 33;  // width of 60 * tick rate
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [PPR_W-1:0]     PPR_RESET     = PPR_W'(1);
   localparam logic [TICK_W-1:0]    TICK_RESET    = TICK_W'(1000000);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PPR           = 2'd0,
      CSR_TICK_RATE     = 2'd1,
      CSR_STALL_TIMEOUT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      LANE_IDLE,
      LANE_MUL,
      LANE_DIV,
      LANE_DONE
   } lane_state_type;

   typedef struct packed {
      logic start;     // a new word is accepted this cycle
      logic edge_hit;  // this lane's encoder has an edge in that word
      logic ack;       // the finished result is taken by the merge stage
   } lane_ctl_type;

   typedef struct packed {
      logic             idle;
      logic             done;
      logic             stopped;
      logic [RPM_W-1:0] rpm;
   } lane_stat_type;

endpackage

### rtl/core/dept_if.sv
// Handshake interfaces of the tachometer: request, response and register write channels.
interface dept_req_if;
   logic                     valid;
   logic                     ready;
   logic [dept_pkg::TS_W-1:0] timestamp;
   logic                     right_edge;
   logic                     left_edge;

   modport source (output valid, timestamp, right_edge, left_edge, input ready);
   modport sink   (input valid, timestamp, right_edge, left_edge, output ready);
endinterface

interface dept_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [dept_pkg::RPM_W-1:0] right_rpm;
   logic [dept_pkg::RPM_W-1:0] left_rpm;
   logic                       right_stopped;
   logic                       left_stopped;

   modport source (output valid, right_rpm, left_rpm, right_stopped, left_stopped,
                   input ready);
   modport sink   (input valid, right_rpm, left_rpm, right_stopped, left_stopped,
                   output ready);
endinterface

interface dept_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dept_pkg::CSR_IDX_W-1:0]  index;
   logic [dept_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/dept_lane.sv
// One encoder channel: edge time and period state, stall check and a radix-2 speed divider.
module dept_lane #(
   parameter int COUNTER_WIDTH = 32,
   parameter int FRACTION_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dept_pkg::lane_ctl_type           ctl,
   input  logic [dept_pkg::TS_W-1:0]        timestamp,
   input  logic [dept_pkg::PPR_W-1:0]       pulses_per_rev,
   input  logic [dept_pkg::TICK_W-1:0]      tick_rate_hz,
   input  logic [dept_pkg::TIMEOUT_W-1:0]   stall_timeout_ticks,
   output dept_pkg::lane_stat_type          stat
);

   localparam int NUM_W = dept_pkg::TICKX60_W + FRACTION_BITS;
   localparam int DEN_W = COUNTER_WIDTH + dept_pkg::PPR_W;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int RPM_W = dept_pkg::RPM_W;

   dept_pkg::lane_state_type state_ff, state_in;
   logic [COUNTER_WIDTH-1:0] edge_time_ff, edge_time_in;
   logic [COUNTER_WIDTH-1:0] period_ff, period_in;
   logic                     stopped_ff, stopped_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic [COUNTER_WIDTH-1:0]       now;
   logic [COUNTER_WIDTH-1:0]       since_edge;
   logic [COUNTER_WIDTH-1:0]       period_next;
   logic [COUNTER_WIDTH-1:0]       elapsed;
   logic [dept_pkg::PPR_W-1:0]     ppr_eff;
   logic [DEN_W-1:0]               den_prod;
   logic [dept_pkg::TICKX60_W-1:0] tick_x60;
   logic [DEN_W:0]                 rem_shift;
   logic [DEN_W:0]                 rem_diff;
   logic [NUM_W+RPM_W-1:0]         quot_wide;
   logic                           quot_sat;
   logic [RPM_W-1:0]               rpm_sat;

   assign now         = timestamp[COUNTER_WIDTH-1:0];
   assign since_edge  = now - edge_time_ff;
   assign period_next = ctl.edge_hit ? since_edge : period_ff;
   // An edge in this word restarts the elapsed time at zero.
   assign elapsed     = ctl.edge_hit ? '0 : since_edge;

   assign ppr_eff  = (pulses_per_rev == '0) ? dept_pkg::PPR_W'(1) : pulses_per_rev;
   assign den_prod = DEN_W'(period_ff) * DEN_W'(ppr_eff);
   // 60 * f = 64 * f - 4 * f
   assign tick_x60 = (dept_pkg::TICKX60_W'(tick_rate_hz) << 6)
                   - (dept_pkg::TICKX60_W'(tick_rate_hz) << 2);

   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   assign quot_wide = {{RPM_W{1'b0}}, num_ff};
   assign quot_sat  = |quot_wide[NUM_W+RPM_W-1:RPM_W];
   assign rpm_sat   = quot_sat ? {RPM_W{1'b1}} : quot_wide[RPM_W-1:0];

   always_comb begin
      state_in     = state_ff;
      edge_time_in = edge_time_ff;
      period_in    = period_ff;
      stopped_in   = stopped_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      case (state_ff)
         dept_pkg::LANE_IDLE: begin
            if (ctl.start) begin
               if (ctl.edge_hit) begin
                  edge_time_in = now;
               end
               period_in  = period_next;
               stopped_in = (period_next == '0)
                          || (dept_pkg::TIMEOUT_W'(elapsed) > stall_timeout_ticks);
               state_in   = dept_pkg::LANE_MUL;
            end
         end
         dept_pkg::LANE_MUL: begin
            den_in   = den_prod;
            num_in   = NUM_W'(tick_x60) << FRACTION_BITS;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = dept_pkg::LANE_DIV;
         end
         dept_pkg::LANE_DIV: begin
            // Restoring division: one quotient bit per cycle, shifted in below the dividend.
            if (!rem_diff[DEN_W]) begin
               rem_in = rem_diff[DEN_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DEN_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = dept_pkg::LANE_DONE;
            end
         end
         dept_pkg::LANE_DONE: begin
            if (ctl.ack) begin
               state_in = dept_pkg::LANE_IDLE;
            end
         end
         default: begin
            state_in = dept_pkg::LANE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dept_pkg::LANE_IDLE;
         edge_time_ff <= '0;
         period_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         edge_time_ff <= edge_time_in;
         period_ff    <= period_in;
      end
      stopped_ff <= stopped_in;
      den_ff     <= den_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
   end

   assign stat.idle    = (state_ff == dept_pkg::LANE_IDLE);
   assign stat.done    = (state_ff == dept_pkg::LANE_DONE);
   assign stat.stopped = stopped_ff;
   assign stat.rpm     = stopped_ff ? '0 : rpm_sat;

endmodule

### rtl/core/dept_merge.sv
// Merge stage: joins the two lane results into one response word held in an output register.
module dept_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  dept_pkg::lane_stat_type right_stat,
   input  dept_pkg::lane_stat_type left_stat,
   output logic                    slot_free,
   dept_rsp_if.source              rsp_ch
);

   logic                       valid_ff, valid_in;
   logic [dept_pkg::RPM_W-1:0] right_rpm_ff, left_rpm_ff;
   logic                       right_stopped_ff, left_stopped_ff;

   assign slot_free = !valid_ff || rsp_ch.ready;
   assign valid_in  = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         right_rpm_ff     <= right_stat.rpm;
         left_rpm_ff      <= left_stat.rpm;
         right_stopped_ff <= right_stat.stopped;
         left_stopped_ff  <= left_stat.stopped;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.right_rpm     = right_rpm_ff;
   assign rsp_ch.left_rpm      = left_rpm_ff;
   assign rsp_ch.right_stopped = right_stopped_ff;
   assign rsp_ch.left_stopped  = left_stopped_ff;

endmodule

### rtl/core/dual_encoder_period_tachometer.sv
// A word accepted on the request channel passes through the lane states IDLE, MUL
// and DIV, where the dividers form one quotient bit per cycle, then waits in DONE
// until the output register is free. A new word is accepted only after both lanes
// have handed off; a finished response waits in the output register while the next word is accepted.
// Reset (synchronous, active high) clears both edge times and periods to zero and
// loads the registers with 1 pulse per revolution, 1 MHz ticks and a 100000-tick timeout.
module dual_encoder_period_tachometer #(
   parameter int COUNTER_WIDTH = 32,
   parameter int FRACTION_BITS = 8
) (
   input logic        clock,
   input logic        reset,
   dept_req_if.sink   req_ch,
   dept_rsp_if.source rsp_ch,
   dept_csr_if.sink   csr_ch
);

   // Configuration registers. The port is always ready; the user must write only while the block is idle,
   // which the block itself does not enforce, so the lanes see stable values during a division.
   logic [dept_pkg::PPR_W-1:0]     ppr_ff, ppr_in;
   logic [dept_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic [dept_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      ppr_in     = ppr_ff;
      tick_in    = tick_ff;
      timeout_in = timeout_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            dept_pkg::CSR_PPR:           ppr_in     = csr_ch.data[dept_pkg::PPR_W-1:0];
            dept_pkg::CSR_TICK_RATE:     tick_in    = csr_ch.data[dept_pkg::TICK_W-1:0];
            dept_pkg::CSR_STALL_TIMEOUT: timeout_in = csr_ch.data[dept_pkg::TIMEOUT_W-1:0];
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff     <= dept_pkg::PPR_RESET;
         tick_ff    <= dept_pkg::TICK_RESET;
         timeout_ff <= dept_pkg::TIMEOUT_RESET;
      end else begin
         ppr_ff     <= ppr_in;
         tick_ff    <= tick_in;
         timeout_ff <= timeout_in;
      end
   end

   // The two lanes start together on every accepted word and finish in the same
   // cycle. A new word is taken as soon as both lanes have handed their result
   // to the merge stage, even if that response has not been taken downstream.
   dept_pkg::lane_ctl_type  right_ctl, left_ctl;
   dept_pkg::lane_stat_type right_stat, left_stat;
   logic                    accept;
   logic                    slot_free;
   logic                    handoff;

   assign req_ch.ready = right_stat.idle && left_stat.idle;
   assign accept       = req_ch.valid && req_ch.ready;
   assign handoff      = right_stat.done && left_stat.done && slot_free;

   assign right_ctl.start    = accept;
   assign right_ctl.edge_hit = req_ch.right_edge;
   assign right_ctl.ack      = handoff;
   assign left_ctl.start     = accept;
   assign left_ctl.edge_hit  = req_ch.left_edge;
   assign left_ctl.ack       = handoff;

   dept_lane #(
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_right_lane (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (right_ctl),
      .timestamp           (req_ch.timestamp),
      .pulses_per_rev      (ppr_ff),
      .tick_rate_hz        (tick_ff),
      .stall_timeout_ticks (timeout_ff),
      .stat                (right_stat)
   );

   dept_lane #(
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_left_lane (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (left_ctl),
      .timestamp           (req_ch.timestamp),
      .pulses_per_rev      (ppr_ff),
      .tick_rate_hz        (tick_ff),
      .stall_timeout_ticks (timeout_ff),
      .stat                (left_stat)
   );

   dept_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (handoff),
      .right_stat (right_stat),
      .left_stat  (left_stat),
      .slot_free  (slot_free),
      .rsp_ch     (rsp_ch)
   );

   // The lanes run in lockstep, so they must agree on being idle and done.
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (right_stat.idle == left_stat.idle) && (right_stat.done == left_stat.done))
      else $error("tachometer lanes out of step");

   // Once a word is accepted, no further word is taken until its result is handed off.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("second word accepted while one is in flight");

   // A handoff always leaves a valid response in the output register.
   a_handoff_shows: assert property (@(posedge clock) disable iff (reset)
      handoff |=> rsp_ch.valid)
      else $error("handed-off result not shown on the response channel");

   // A stopped lane never reports a nonzero speed to the merge stage.
   a_stopped_zero: assert property (@(posedge clock) disable iff (reset)
      handoff |-> (!right_stat.stopped || right_stat.rpm == '0)
               && (!left_stat.stopped || left_stat.rpm == '0))
      else $error("stopped lane reports nonzero speed");

endmodule
